// ===== rtl/core/hsvc_pkg.sv =====
// shared types and constants for the hsv to rgb converter
// no dependencies
package hsvc_pkg;

    localparam int COMPONENT_BITS = 16;

    // hue sector codes, sector five falls to the default routing
    localparam logic [2:0] SECT_RED    = 3'd0;
    localparam logic [2:0] SECT_YELLOW = 3'd1;
    localparam logic [2:0] SECT_GREEN  = 3'd2;
    localparam logic [2:0] SECT_CYAN   = 3'd3;
    localparam logic [2:0] SECT_BLUE   = 3'd4;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

// ===== rtl/core/hsvc_if.sv =====
// item channels of the hsv to rgb converter: hsv in, rgb out
// depends on hsvc_pkg for the default component width
interface hsvc_in_if #(
    parameter int W = hsvc_pkg::COMPONENT_BITS
);
    logic         valid;
    logic         ready;
    logic [W-1:0] hue;
    logic [W-1:0] saturation;
    logic [W-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvc_out_if #(
    parameter int W = hsvc_pkg::COMPONENT_BITS
);
    logic         valid;
    logic         ready;
    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/core/hsvc_datapath.sv =====
// four-stage arithmetic datapath: sector split, scaled products, routing
// depends on hsvc_pkg
module hsvc_datapath #(
    parameter int COMPONENT_BITS = hsvc_pkg::COMPONENT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hsvc_pkg::t_pipe_en        i_en,
    input  logic [COMPONENT_BITS-1:0] i_hue,
    input  logic [COMPONENT_BITS-1:0] i_saturation,
    input  logic [COMPONENT_BITS-1:0] i_brightness,
    output logic [COMPONENT_BITS-1:0] o_red,
    output logic [COMPONENT_BITS-1:0] o_green,
    output logic [COMPONENT_BITS-1:0] o_blue
);
    import hsvc_pkg::*;

    localparam int W = COMPONENT_BITS;
    localparam logic [W:0] FULL = {1'b1, {W{1'b0}}};

    // stage 1
    logic [W+2:0] h6;
    logic [2:0]   r1_sec;
    logic [W-1:0] r1_f;
    logic [W-1:0] r1_s;
    logic [W-1:0] r1_v;

    // stage 2
    logic [W:0]     full_minus_f;
    logic [W:0]     full_minus_s;
    logic [2*W-1:0] prod_sf;
    logic [2*W:0]   prod_sg;
    logic [2*W:0]   prod_m;
    logic [2:0]     r2_sec;
    logic [W-1:0]   r2_sf;
    logic [W-1:0]   r2_sg;
    logic [W-1:0]   r2_m;
    logic [W-1:0]   r2_v;

    // stage 3
    logic [W:0]   full_minus_sf;
    logic [W:0]   full_minus_sg;
    logic [2*W:0] prod_n;
    logic [2*W:0] prod_p;
    logic [2:0]   r3_sec;
    logic [W-1:0] r3_n;
    logic [W-1:0] r3_p;
    logic [W-1:0] r3_m;
    logic [W-1:0] r3_v;

    // stage 4
    logic [W-1:0] n_red;
    logic [W-1:0] n_green;
    logic [W-1:0] n_blue;
    logic [W-1:0] r_red;
    logic [W-1:0] r_green;
    logic [W-1:0] r_blue;

    assign h6 = (W+3)'({i_hue, 2'b00}) + (W+3)'({i_hue, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_sec <= h6[W+2:W];
            r1_f   <= h6[W-1:0];
            r1_s   <= i_saturation;
            r1_v   <= i_brightness;
        end
    end

    assign full_minus_f = FULL - {1'b0, r1_f};
    assign full_minus_s = FULL - {1'b0, r1_s};
    assign prod_sf = (2*W)'(r1_s) * (2*W)'(r1_f);
    assign prod_sg = (2*W+1)'(r1_s) * (2*W+1)'(full_minus_f);
    assign prod_m  = (2*W+1)'(r1_v) * (2*W+1)'(full_minus_s);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_sec <= r1_sec;
            r2_sf  <= prod_sf[2*W-1:W];
            r2_sg  <= prod_sg[2*W-1:W];
            r2_m   <= prod_m[2*W-1:W];
            r2_v   <= r1_v;
        end
    end

    assign full_minus_sf = FULL - {1'b0, r2_sf};
    assign full_minus_sg = FULL - {1'b0, r2_sg};
    assign prod_n = (2*W+1)'(r2_v) * (2*W+1)'(full_minus_sf);
    assign prod_p = (2*W+1)'(r2_v) * (2*W+1)'(full_minus_sg);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_sec <= r2_sec;
            r3_n   <= prod_n[2*W-1:W];
            r3_p   <= prod_p[2*W-1:W];
            r3_m   <= r2_m;
            r3_v   <= r2_v;
        end
    end

    always_comb begin
        unique case (r3_sec)
            SECT_RED: begin
                n_red = r3_v; n_green = r3_p; n_blue = r3_m;
            end
            SECT_YELLOW: begin
                n_red = r3_n; n_green = r3_v; n_blue = r3_m;
            end
            SECT_GREEN: begin
                n_red = r3_m; n_green = r3_v; n_blue = r3_p;
            end
            SECT_CYAN: begin
                n_red = r3_m; n_green = r3_n; n_blue = r3_v;
            end
            SECT_BLUE: begin
                n_red = r3_p; n_green = r3_m; n_blue = r3_v;
            end
            // magenta sector
            default: begin
                n_red = r3_v; n_green = r3_m; n_blue = r3_n;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    a_zero_sat_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en.s2 && r1_s == '0 |=> r2_m == r2_v && r2_sf == '0 && r2_sg == '0)
        else $error("zero saturation did not give m equal to v");

    a_split_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en.s2 |=> ((W+1)'(r2_sf) + (W+1)'(r2_sg)) <= {1'b0, $past(r1_s)})
        else $error("s*f plus s*(1-f) exceeds saturation");

endmodule

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// hsv to rgb converter: latency four register stages, an accepted item moves
// through r_vld[0] to r_vld[3], which drives o_rgb.valid; one item per clock
// sustained unless o_rgb.ready is low; the rate is set by the two multiplier
// stages, each fully pipelined; reset clears only the stage valid bits, the
// pipeline then reads empty; depends on hsvc_pkg, hsvc_if and hsvc_datapath
module hsv_to_rgb_converter #(
    parameter int COMPONENT_BITS = hsvc_pkg::COMPONENT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsvc_in_if.sink    i_hsv,
    hsvc_out_if.source o_rgb
);
    import hsvc_pkg::*;

    logic [3:0] r_vld;
    t_pipe_en   en;

    always_comb begin
        en.s4 = !r_vld[3] || o_rgb.ready;
        en.s3 = !r_vld[2] || en.s4;
        en.s2 = !r_vld[1] || en.s3;
        en.s1 = !r_vld[0] || en.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en.s1) r_vld[0] <= i_hsv.valid;
            if (en.s2) r_vld[1] <= r_vld[0];
            if (en.s3) r_vld[2] <= r_vld[1];
            if (en.s4) r_vld[3] <= r_vld[2];
        end
    end

    assign i_hsv.ready = en.s1;
    assign o_rgb.valid = r_vld[3];

    hsvc_datapath #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_hue       (i_hsv.hue),
        .i_saturation(i_hsv.saturation),
        .i_brightness(i_hsv.brightness),
        .o_red       (o_rgb.red),
        .o_green     (o_rgb.green),
        .o_blue      (o_rgb.blue)
    );

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hsv.valid && i_hsv.ready |=> r_vld[0])
        else $error("accepted item not held in first stage");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_hsv.ready)
        else $error("empty first stage refuses an item");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && r_vld[3] && !o_rgb.ready |=> r_vld[2] && r_vld[3])
        else $error("stalled item dropped from the pipeline");

endmodule

// ===== sim/hsvc_checker.sv =====
`timescale 1ns / 100ps
// checker for the hsv to rgb converter: works out the rgb item due for each hsv item
// taken in and compares it, in order, with each rgb item handed out
// depends on hsvc_pkg and the channel interfaces in hsvc_if
module hsvc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hsvc_in_if   i_hsv,
    hsvc_out_if  i_rgb,
    output int   o_mismatch_count,
    output int   o_pending
);
    import hsvc_pkg::*;

    localparam int W = COMPONENT_BITS;

    typedef struct packed {
        logic [W-1:0] red;
        logic [W-1:0] green;
        logic [W-1:0] blue;
    } t_rgb_item;

    t_rgb_item expected_rgb[$];
    int        mismatches = 0;

    // a * (1.0 - x) with 1.0 as 2^W, truncated
    function automatic logic [W-1:0] scale_complement(input logic [W-1:0] a,
                                                      input logic [W-1:0] x);
        logic [W:0]   k;
        logic [2*W:0] prod;
        logic [W-1:0] res;
        k    = {1'b1, {W{1'b0}}} - {1'b0, x};
        prod = (2*W+1)'(a) * (2*W+1)'(k);
        res  = prod[2*W-1:W];
        return res;
    endfunction

    function automatic t_rgb_item convert_hsv(input logic [W-1:0] h,
                                              input logic [W-1:0] s,
                                              input logic [W-1:0] v);
        logic [W+2:0]   h6;
        logic [2:0]     sector;
        logic [W-1:0]   f;
        logic [2*W-1:0] sf_prod;
        logic [W-1:0]   sf;
        logic [W-1:0]   sg;
        logic [W-1:0]   m;
        logic [W-1:0]   n;
        logic [W-1:0]   p;
        t_rgb_item      c;
        h6      = (W+3)'(h) * (W+3)'(6);
        sector  = h6[W+2:W];
        f       = h6[W-1:0];
        sf_prod = (2*W)'(s) * (2*W)'(f);
        sf      = sf_prod[2*W-1:W];
        sg      = scale_complement(s, f);
        m       = scale_complement(v, s);
        n       = scale_complement(v, sf);
        p       = scale_complement(v, sg);
        case (sector)
            SECT_RED: begin
                c.red = v; c.green = p; c.blue = m;
            end
            SECT_YELLOW: begin
                c.red = n; c.green = v; c.blue = m;
            end
            SECT_GREEN: begin
                c.red = m; c.green = v; c.blue = p;
            end
            SECT_CYAN: begin
                c.red = m; c.green = n; c.blue = v;
            end
            SECT_BLUE: begin
                c.red = p; c.green = m; c.blue = v;
            end
            default: begin
                c.red = v; c.green = m; c.blue = n;
            end
        endcase
        return c;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rgb_item got;
        t_rgb_item want;
        if (!i_rst_n) begin
            o_pending        <= 0;
            o_mismatch_count <= mismatches;
        end else begin
            if (i_hsv.valid && i_hsv.ready) begin
                expected_rgb.push_back(convert_hsv(i_hsv.hue, i_hsv.saturation,
                                                   i_hsv.brightness));
            end
            if (i_rgb.valid && i_rgb.ready) begin
                got = {i_rgb.red, i_rgb.green, i_rgb.blue};
                if (expected_rgb.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected rgb item r=%h g=%h b=%h",
                                 $realtime, got.red, got.green, got.blue);
                    end
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: rgb mismatch expected r=%h g=%h b=%h",
                                      " got r=%h g=%h b=%h"},
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
            o_pending        <= expected_rgb.size();
            o_mismatch_count <= mismatches;
        end
    end

endmodule

// ===== sim/tb_hsv_to_rgb_converter.sv =====
`timescale 1ns / 100ps
// testbench top for the hsv to rgb converter: clock, reset, hsv items and rgb back-pressure
// depends on hsvc_pkg, hsvc_if, hsv_to_rgb_converter and hsvc_checker
module tb_hsv_to_rgb_converter;
    import hsvc_pkg::*;

    localparam int W               = COMPONENT_BITS;
    localparam int ITEMS_PER_PHASE = 390;
    localparam int HOLD_ITEMS      = 40;
    localparam int HOLD_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;

    hsvc_in_if  hsv_if ();
    hsvc_out_if rgb_if ();

    int mismatch_count;
    int pending_rgb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int cycle_count    = 0;

    hsv_to_rgb_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hsv   (hsv_if),
        .o_rgb   (rgb_if)
    );

    hsvc_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_hsv            (hsv_if),
        .i_rgb            (rgb_if),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_rgb)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // rgb side: random stalls, or one long hold-off on request
    initial begin
        rgb_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                rgb_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            rgb_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_hsv(input logic [W-1:0] h, input logic [W-1:0] s,
                            input logic [W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            hsv_if.valid <= 1'b0;
            @(posedge clk);
        end
        hsv_if.valid      <= 1'b1;
        hsv_if.hue        <= h;
        hsv_if.saturation <= s;
        hsv_if.brightness <= v;
        do @(posedge clk); while (!hsv_if.ready);
    endtask

    task automatic wait_idle();
        hsv_if.valid <= 1'b0;
        do @(posedge clk); while (pending_rgb != 0);
    endtask

    // full range, with a bias toward zero and full scale
    function automatic logic [W-1:0] rand_level();
        logic [W-1:0] lvl;
        case ($urandom_range(7))
            0: lvl = '0;
            1: lvl = '1;
            default: lvl = W'($urandom);
        endcase
        return lvl;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_hsv(W'($urandom), rand_level(), rand_level());
    endtask

    initial begin
        int unsigned boundary_hues[12];
        boundary_hues = '{0, 10922, 10923, 21845, 21846, 32767,
                          32768, 43690, 43691, 54612, 54614, 65535};
        rst_n             <= 1'b0;
        hsv_if.valid      <= 1'b0;
        hsv_if.hue        <= '0;
        hsv_if.saturation <= '0;
        hsv_if.brightness <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // extremes and zero saturation
        send_hsv('0, '0, '0);
        send_hsv('1, '1, '1);
        send_hsv('0, '1, '1);
        send_hsv('1, '0, '1);
        send_hsv(16'h1234, '0, 16'h8000);
        send_hsv(16'h5555, 16'h8000, 16'h8000);
        // both ends of every sector but the top of sector four (54613 is not sent), sector five included
        foreach (boundary_hues[i]) begin
            send_hsv(W'(boundary_hues[i]), '1, (i % 2) ? 16'hc000 : 16'hffff);
        end
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 53; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 53;
                end
                default: begin
                    send_idle_pct = 11; recv_stall_pct = 11;
                end
            endcase
            if (ph == 0) begin
                hold_req = 1'b1;
                send_random(HOLD_ITEMS);
            end
            send_random(ITEMS_PER_PHASE);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_rgb == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hsvc_pkg.sv
rtl/core/hsvc_if.sv
rtl/core/hsvc_datapath.sv
rtl/core/hsv_to_rgb_converter.sv
sim/hsvc_checker.sv
sim/tb_hsv_to_rgb_converter.sv
